@@ hdl/wphg_pkg.sv @@
`default_nettype none

package wphg_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int unsigned COORD_WIDTH_DEF     = 16;
  localparam int unsigned TABLE_ADDR_BITS_DEF = 10;

  // Field and datapath widths.
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned STEP_W   = 32;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned SINE_W   = 17;  // Q0.16 with room for exactly one
  localparam int unsigned FRAC_W   = 33;  // Q1.32 wave amplitude
  localparam int unsigned SPAN_W   = 15;
  localparam int unsigned PROD_W   = FRAC_W + SPAN_W;

  localparam logic [FIELD_W-1:0] BASE_HEIGHT    = 16'd32000;
  localparam logic [SPAN_W-1:0]  SPAN_HEIGHT    = 15'd19200;
  localparam logic [STEP_W-1:0]  PHASE_STEP_RST = 32'd21474836;

  // Constants for building the sine-squared table at elaboration.
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [7:0]  HORNER_DIV [5] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

  typedef enum logic [2:0] {
    MODE_SINE_H = 3'd0,
    MODE_SINE_V = 3'd1,
    MODE_SINE_D = 3'd2,
    MODE_TRI_H  = 3'd3,
    MODE_TRI_V  = 3'd4,
    MODE_TRI_D  = 3'd5
  } pattern_mode_e;

  typedef enum logic [0:0] {
    CFG_PATTERN_MODE = 1'b0,
    CFG_PHASE_STEP   = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    WAVE_FLAT,
    WAVE_SINE,
    WAVE_TRI
  } wave_kind_e;

  // One table entry: sin^2(pi*k/2^tab_bits) in Q0.16, through a truncated
  // Taylor series in Horner form. Only ever evaluated at elaboration.
  function automatic logic [SINE_W-1:0] sine_sq_entry(input int unsigned k,
                                                       input int unsigned tab_bits);
    logic [63:0] n;
    logic [63:0] kk;
    logic [63:0] kf;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] s;
    n  = 64'd1 << tab_bits;
    kk = 64'(k) & (n - 64'd1);
    kf = (kk <= (n >> 1)) ? kk : n - kk;
    y  = (PI_Q30 * kf) >> tab_bits;
    y2 = (y * y) >> 30;
    r  = Q30_ONE;
    for (int i = 0; i < 5; i++) begin
      t = ((y2 * r) >> 30) / 64'(HORNER_DIV[i]);
      r = (t < Q30_ONE) ? Q30_ONE - t : 64'd0;
    end
    s = (y * r) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    return SINE_W'((s * s) >> 44);
  endfunction

endpackage

`default_nettype wire

@@ hdl/wphg_sine_rom.sv @@
`default_nettype none

module wphg_sine_rom import wphg_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic [TABLE_ADDR_BITS-1:0] addr_i,
  output logic      [SINE_W-1:0]          data_o
);

  localparam int unsigned Depth = 1 << TABLE_ADDR_BITS;

  logic [SINE_W-1:0] rom_tbl [Depth];
  logic [SINE_W-1:0] data_q;

  for (genvar k = 0; k < Depth; k++) begin : g_entry
    localparam logic [SINE_W-1:0] EntryVal = sine_sq_entry(k, TABLE_ADDR_BITS);
    assign rom_tbl[k] = EntryVal;
  end

  // Synchronous read: the word appears in the cycle after its address.
  always_ff @(posedge clk_i) begin
    data_q <= rom_tbl[addr_i];
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ hdl/wave_pattern_height_generator_unit.sv @@
// Four-stage pipeline: coordinate select, phase multiply, table read or
// triangle fold, then scale and offset. A pixel taken on start gives its height
// with done_o once it has passed the stage registers, and one pixel is taken in every cycle, so busy
// stays low. The receiver cannot stall: each height is shown for one cycle.
// Reset clears the stage valid bits and loads the mode and phase step defaults.
`default_nettype none

module wave_pattern_height_generator_unit import wphg_pkg::*; #(
  parameter int unsigned COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int unsigned TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [STEP_W-1:0]  cfg_data_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [FIELD_W-1:0] row_index_i,
  input  wire logic [FIELD_W-1:0] column_index_i,
  output logic                    done_o,
  output logic      [FIELD_W-1:0] height_value_o
);

  localparam int unsigned TW       = COORD_WIDTH + 1;
  localparam int unsigned RoundSh  = PHASE_W - TABLE_ADDR_BITS;
  localparam logic [PHASE_W-1:0] AddrHalf = PHASE_W'(1) << (RoundSh - 1);
  localparam logic [PROD_W-1:0]  ProdHalf = PROD_W'(1) << (PHASE_W - 1);

  // Configuration registers.
  logic [2:0]        mode_q;
  logic [STEP_W-1:0] phase_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 3'(MODE_SINE_H);
      phase_step_q <= PHASE_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_PATTERN_MODE: mode_q       <= cfg_data_i[2:0];
        CFG_PHASE_STEP:   phase_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: pick the coordinate and the wave shape.
  logic [COORD_WIDTH-1:0] row_c;
  logic [COORD_WIDTH-1:0] col_c;
  logic [TW-1:0]          t_d;
  wave_kind_e             wave_d;

  assign row_c = COORD_WIDTH'(row_index_i);
  assign col_c = COORD_WIDTH'(column_index_i);

  always_comb begin
    t_d    = '0;
    wave_d = WAVE_FLAT;
    case (mode_q)
      MODE_SINE_H: begin
        t_d    = TW'(col_c);
        wave_d = WAVE_SINE;
      end
      MODE_SINE_V: begin
        t_d    = TW'(row_c);
        wave_d = WAVE_SINE;
      end
      MODE_SINE_D: begin
        t_d    = TW'(row_c) + TW'(col_c);
        wave_d = WAVE_SINE;
      end
      MODE_TRI_H: begin
        t_d    = TW'(col_c);
        wave_d = WAVE_TRI;
      end
      MODE_TRI_V: begin
        t_d    = TW'(row_c);
        wave_d = WAVE_TRI;
      end
      MODE_TRI_D: begin
        t_d    = TW'(row_c) + TW'(col_c);
        wave_d = WAVE_TRI;
      end
      default: begin
        t_d    = '0;
        wave_d = WAVE_FLAT;
      end
    endcase
  end

  logic          v1_q;
  logic [TW-1:0] t1_q;
  wave_kind_e    wave1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q    <= t_d;
    wave1_q <= wave_d;
  end

  // Stage 2: the phase is the low word of t times the step, so it wraps
  // once per period by itself.
  logic [PHASE_W-1:0] t1_ext;
  logic [PHASE_W-1:0] phase_d;

  assign t1_ext  = PHASE_W'(t1_q);
  assign phase_d = t1_ext * phase_step_q;

  logic               v2_q;
  logic [PHASE_W-1:0] phase2_q;
  wave_kind_e         wave2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    phase2_q <= phase_d;
    wave2_q  <= wave1_q;
  end

  // Stage 3: the table address is the phase rounded to the table size;
  // the triangle folds the upper half of the period back down.
  logic [PHASE_W-1:0]         addr_sum;
  logic [TABLE_ADDR_BITS-1:0] rom_addr;
  logic [SINE_W-1:0]          rom_data;
  logic [FRAC_W-1:0]          tri_d;

  assign addr_sum = phase2_q + AddrHalf;
  assign rom_addr = addr_sum[PHASE_W-1 -: TABLE_ADDR_BITS];

  always_comb begin
    if (!phase2_q[PHASE_W-1]) begin
      tri_d = {phase2_q, 1'b0};
    end else begin
      tri_d = (FRAC_W'(1) << PHASE_W) - FRAC_W'(phase2_q);
      tri_d = {tri_d[FRAC_W-2:0], 1'b0};
    end
  end

  wphg_sine_rom #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_sine_rom (
    .clk_i (clk_i),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  logic              v3_q;
  logic [FRAC_W-1:0] tri3_q;
  wave_kind_e        wave3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tri3_q  <= tri_d;
    wave3_q <= wave2_q;
  end

  // Stage 4: both waves are brought to Q1.32, so one scale and round serves.
  logic [FRAC_W-1:0]  frac;
  logic [PROD_W-1:0]  prod;
  logic [FIELD_W-1:0] height_d;

  always_comb begin
    case (wave3_q)
      WAVE_SINE: frac = {rom_data, 16'd0};
      WAVE_TRI:  frac = tri3_q;
      default:   frac = '0;
    endcase
  end

  assign prod     = PROD_W'(frac) * PROD_W'(SPAN_HEIGHT) + ProdHalf;
  assign height_d = BASE_HEIGHT + FIELD_W'(prod[PROD_W-1:PHASE_W]);

  logic               done_q;
  logic [FIELD_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    height_q <= height_d;
  end

  assign busy           = 1'b0;
  assign done_o         = done_q;
  assign height_value_o = height_q;

  // Every accepted word comes out on done_o, through the stage registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##4 done_o)
    else $error("accepted word did not come out after four cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 4))
    else $error("result word without an accepted input");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (height_value_o >= BASE_HEIGHT) && (height_value_o <= 16'd51200))
    else $error("height out of range");

  a_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && (wave3_q == WAVE_FLAT)) |=> (height_value_o == BASE_HEIGHT))
    else $error("undefined mode did not give the base height");

endmodule

`default_nettype wire
